### src/ubd_pkg.sv
// ----------------------------------------------------------------------------
// ubd_pkg
// Types, constants and helpers shared by the baud divisor encoder.
// ----------------------------------------------------------------------------
package ubd_pkg;

   localparam int unsigned LOW_SPEED_CLOCK_HZ  = 48000000;
   localparam int unsigned HIGH_SPEED_CLOCK_HZ = 120000000;

   // Dividends: half the low-speed clock, and eight tenths of the high-speed clock.
   localparam int unsigned LS_NUM  = LOW_SPEED_CLOCK_HZ / 2;
   localparam int unsigned HS_NUM  = HIGH_SPEED_CLOCK_HZ * 8 / 10;
   localparam int unsigned NUM_MAX = (LS_NUM > HS_NUM) ? LS_NUM : HS_NUM;
   localparam int unsigned NUM_W   = $clog2(NUM_MAX + 1);

   localparam int unsigned BAUD_W     = 31;
   localparam int unsigned REM_W      = BAUD_W;
   localparam int unsigned D3_W       = 35;
   localparam int unsigned FAM_W      = 4;
   localparam int unsigned IFN_W      = 2;
   localparam int unsigned SIO_W      = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 4;
   localparam int unsigned SIO_COUNT  = 10;

   typedef logic [BAUD_W-1:0] baud_type;
   typedef logic [REM_W-1:0]  rem_type;
   typedef logic [NUM_W-1:0]  num_type;
   typedef logic [FAM_W-1:0]  fam_type;
   typedef logic [IFN_W-1:0]  ifn_type;
   typedef logic [SIO_W-1:0]  sio_type;

   localparam fam_type FAM_SIO   = 4'd0;
   localparam fam_type FAM_AM    = 4'd1;
   localparam fam_type FAM_BM    = 4'd2;
   localparam fam_type FAM_2232C = 4'd3;
   localparam fam_type FAM_RL    = 4'd4;
   localparam fam_type FAM_FTX   = 4'd5;
   localparam fam_type FAM_2232H = 4'd6;
   localparam fam_type FAM_4232H = 4'd7;
   localparam fam_type FAM_232H  = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHIP_FAMILY      = 2'd0,
      CSR_TRACKER_QUIRK    = 2'd1,
      CSR_INTERFACE_NUMBER = 2'd2
   } csr_index_type;

   localparam baud_type RATE_DEFAULT   = 31'd9600;
   localparam baud_type RATE_LS_MAX    = 31'd3000000;
   localparam baud_type RATE_HS_MAX    = 31'd12000000;
   localparam baud_type RATE_HS_MIN    = 31'd1200;
   localparam baud_type RATE_QUIRK_IN  = 31'd19200;
   localparam baud_type RATE_QUIRK_OUT = 31'd1200000;

   localparam baud_type SIO_RATES [SIO_COUNT] = '{
      31'd300, 31'd600, 31'd1200, 31'd2400, 31'd4800,
      31'd9600, 31'd19200, 31'd38400, 31'd57600, 31'd115200
   };
   localparam sio_type SIO_DEFAULT_IDX = 4'd5;

   localparam logic [15:0] AM_CODE_EIGHTH  = 16'hc000;
   localparam logic [15:0] AM_CODE_HALF    = 16'h4000;
   localparam logic [15:0] AM_CODE_QUARTER = 16'h8000;
   localparam logic [31:0] BM_SPECIAL      = 32'h00004001;
   localparam logic [31:0] HS_FLAG         = 32'h00020000;

   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_SIO,
      MODE_AM,
      MODE_BM,
      MODE_HS
   } mode_type;

   typedef struct packed {
      mode_type mode;
      logic     ok;
      logic     dual;
      ifn_type  ifn;
      sio_type  sio_idx;
   } ctrl_type;

   typedef struct packed {
      baud_type divisor;
      rem_type  rem;
      num_type  num;
      num_type  quot;
      ctrl_type ctrl;
   } cell_type;

   function automatic logic [2:0] frac_code(input logic [2:0] f);
      logic [2:0] code;
      case (f)
         3'd0:    code = 3'd0;
         3'd1:    code = 3'd3;
         3'd2:    code = 3'd2;
         3'd3:    code = 3'd4;
         3'd4:    code = 3'd1;
         3'd5:    code = 3'd5;
         3'd6:    code = 3'd6;
         default: code = 3'd7;
      endcase
      return code;
   endfunction

endpackage

### src/ubd_if.sv
// ----------------------------------------------------------------------------
// ubd_if
// Request, response and register write channels of the baud divisor encoder.
// ----------------------------------------------------------------------------
interface ubd_req_if import ubd_pkg::*; ();
   logic     valid;
   logic     ready;
   baud_type rate_bps;

   modport source (output valid, output rate_bps, input ready);
   modport sink   (input valid, input rate_bps, output ready);
endinterface

interface ubd_rsp_if import ubd_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [15:0] divisor_value;
   logic [15:0] divisor_index;
   logic        rate_ok;

   modport source (output valid, output divisor_value, output divisor_index,
                   output rate_ok, input ready);
   modport sink   (input valid, input divisor_value, input divisor_index,
                   input rate_ok, output ready);
endinterface

interface ubd_csr_if import ubd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/uart_baud_divisor_encoder.sv
// ----------------------------------------------------------------------------
// uart_baud_divisor_encoder
// Turns a requested baud rate into the fractional divisor word of the
// configured bridge chip family, through a row of division cells.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_bus   in         rate_bps
//  rsp_bus   out        divisor_value, divisor_index, rate_ok
//  csr_bus   in         index, data (chip_family, tracker_quirk, interface_number)
//
// One item per cycle sustained while rsp_bus takes results; the path is one cell
// per quotient bit of the clock / rate division, then the output register. Every
// cell advances when empty or when its neighbor takes its item, so bubbles close
// up while a result waits on rsp_bus.
// Reset clears the valid bits and sets chip_family to 1, the other registers to 0.
// Register writes are always taken.
// ----------------------------------------------------------------------------
module uart_baud_divisor_encoder import ubd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ubd_req_if.sink   req_bus,
   ubd_rsp_if.source rsp_bus,
   ubd_csr_if.sink   csr_bus
);

   fam_type  chip_family_ff;
   logic     tracker_quirk_ff;
   ifn_type  interface_number_ff;

   cell_type stage_d [NUM_W+1];
   logic     stage_v [NUM_W+1];
   logic     stage_r [NUM_W+1];

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_family_ff      <= FAM_AM;
         tracker_quirk_ff    <= 1'b0;
         interface_number_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_CHIP_FAMILY:      chip_family_ff      <= csr_bus.data;
            CSR_TRACKER_QUIRK:    tracker_quirk_ff    <= csr_bus.data[0];
            CSR_INTERFACE_NUMBER: interface_number_ff <= csr_bus.data[IFN_W-1:0];
            default: ;
         endcase
      end
   end

   ubd_front u_front (
      .rate_bps         (req_bus.rate_bps),
      .chip_family      (chip_family_ff),
      .tracker_quirk    (tracker_quirk_ff),
      .interface_number (interface_number_ff),
      .cell_out         (stage_d[0])
   );

   assign stage_v[0]    = req_bus.valid;
   assign req_bus.ready = stage_r[0];

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      ubd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (stage_v[i]),
         .ready_in  (stage_r[i]),
         .cell_in   (stage_d[i]),
         .valid_out (stage_v[i+1]),
         .ready_out (stage_r[i+1]),
         .cell_out  (stage_d[i+1])
      );
   end

   ubd_encode u_encode (
      .clock    (clock),
      .reset    (reset),
      .valid_in (stage_v[NUM_W]),
      .ready_in (stage_r[NUM_W]),
      .cell_in  (stage_d[NUM_W]),
      .rsp      (rsp_bus)
   );

   a_accept_enters_row: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> stage_v[1])
      else $error("accepted item did not enter the first cell");

   a_quotient_bounds: assert property (@(posedge clock) disable iff (reset)
      stage_v[NUM_W] |-> (stage_d[NUM_W].rem < stage_d[NUM_W].divisor) &&
                         (stage_d[NUM_W].quot <= NUM_W'(NUM_MAX)))
      else $error("division row produced an out-of-range quotient or remainder");

   a_sio_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.rate_ok && chip_family_ff == FAM_SIO) |->
         (rsp_bus.divisor_index == 16'd0 && rsp_bus.divisor_value < 16'(SIO_COUNT)))
      else $error("table index result out of range");

   a_unknown_family: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && chip_family_ff > FAM_232H) |->
         (!rsp_bus.rate_ok && rsp_bus.divisor_value == 16'd0 &&
          rsp_bus.divisor_index == 16'd0))
      else $error("undefined chip family gave a nonzero result");

endmodule

### src/ubd_front.sv
// ----------------------------------------------------------------------------
// ubd_front
// Picks the encoding, the divisor and the dividend for one requested rate.
// ----------------------------------------------------------------------------
module ubd_front import ubd_pkg::*; (
   input  baud_type rate_bps,
   input  fam_type  chip_family,
   input  logic     tracker_quirk,
   input  ifn_type  interface_number,
   output cell_type cell_out
);

   baud_type baud_n;
   logic     sio_hit;
   sio_type  sio_idx;

   always_comb begin
      baud_n  = (rate_bps == '0) ? RATE_DEFAULT : rate_bps;
      sio_hit = 1'b0;
      sio_idx = SIO_DEFAULT_IDX;
      for (int i = 0; i < SIO_COUNT; i++) begin
         if (baud_n == SIO_RATES[i]) begin
            sio_hit = 1'b1;
            sio_idx = SIO_W'(i);
         end
      end
   end

   always_comb begin
      cell_out              = '0;
      cell_out.num          = NUM_W'(LS_NUM);
      cell_out.divisor      = RATE_DEFAULT;
      cell_out.ctrl.ok      = 1'b1;
      cell_out.ctrl.ifn     = interface_number;
      cell_out.ctrl.sio_idx = sio_idx;
      cell_out.ctrl.dual    = (chip_family == FAM_2232C) || (chip_family == FAM_2232H) ||
                              (chip_family == FAM_4232H) || (chip_family == FAM_232H);
      case (chip_family)
         FAM_SIO: begin
            cell_out.ctrl.mode = MODE_SIO;
            cell_out.ctrl.ok   = sio_hit;
         end
         FAM_AM: begin
            cell_out.ctrl.mode = MODE_AM;
            if (baud_n <= RATE_LS_MAX) begin
               cell_out.divisor = baud_n;
            end else begin
               cell_out.ctrl.ok = 1'b0;
            end
         end
         FAM_BM, FAM_2232C, FAM_RL, FAM_FTX: begin
            cell_out.ctrl.mode = MODE_BM;
            if (baud_n <= RATE_LS_MAX) begin
               cell_out.divisor = (tracker_quirk && baud_n == RATE_QUIRK_IN) ?
                                  RATE_QUIRK_OUT : baud_n;
            end else begin
               cell_out.ctrl.ok = 1'b0;
            end
         end
         FAM_2232H, FAM_4232H, FAM_232H: begin
            if (baud_n <= RATE_HS_MAX && baud_n >= RATE_HS_MIN) begin
               cell_out.ctrl.mode = MODE_HS;
               cell_out.divisor   = baud_n;
               cell_out.num       = NUM_W'(HS_NUM);
            end else if (baud_n < RATE_HS_MIN) begin
               cell_out.ctrl.mode = MODE_BM;
               cell_out.divisor   = baud_n;
            end else begin
               cell_out.ctrl.mode = MODE_BM;
               cell_out.ctrl.ok   = 1'b0;
            end
         end
         default: begin
            cell_out.ctrl.mode = MODE_NONE;
            cell_out.ctrl.ok   = 1'b0;
         end
      endcase
   end

endmodule

### src/ubd_div_cell.sv
// ----------------------------------------------------------------------------
// ubd_div_cell
// One restoring division step: takes the next dividend bit, yields one
// quotient bit, and hands the item on to the next cell.
// ----------------------------------------------------------------------------
module ubd_div_cell import ubd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     valid_in,
   output logic     ready_in,
   input  cell_type cell_in,
   output logic     valid_out,
   input  logic     ready_out,
   output cell_type cell_out
);

   logic             valid_ff;
   cell_type         cell_ff;
   cell_type         cell_in_step;
   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;
   logic             fits;

   always_comb begin
      trial = {cell_in.rem, cell_in.num[NUM_W-1]};
      diff  = trial - {1'b0, cell_in.divisor};
      fits  = trial >= {1'b0, cell_in.divisor};

      cell_in_step      = cell_in;
      cell_in_step.rem  = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      cell_in_step.num  = {cell_in.num[NUM_W-2:0], 1'b0};
      cell_in_step.quot = {cell_in.quot[NUM_W-2:0], fits};
   end

   // advance when empty or when the next cell takes the held item
   assign ready_in = !valid_ff || ready_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_in) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_in && valid_in) begin
         cell_ff <= cell_in_step;
      end
   end

   assign valid_out = valid_ff;
   assign cell_out  = cell_ff;

endmodule

### src/ubd_encode.sv
// ----------------------------------------------------------------------------
// ubd_encode
// Packs the quotient into the divisor word for the chosen encoding and holds
// the result item for the response channel.
// ----------------------------------------------------------------------------
module ubd_encode import ubd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     valid_in,
   output logic     ready_in,
   input  cell_type cell_in,
   ubd_rsp_if.source rsp
);

   logic            valid_ff;
   logic [15:0]     value_ff;
   logic [15:0]     index_ff;
   logic            ok_ff;

   logic [15:0]     value_in;
   logic [15:0]     index_in;

   logic [D3_W-1:0] d3;
   logic [D3_W-1:0] d3_am;
   logic [15:0]     am_div;
   logic [31:0]     frac_div;
   logic [31:0]     word;
   logic [15:0]     idx;

   always_comb begin
      d3    = D3_W'(cell_in.quot);
      d3_am = (d3[2:0] == 3'd7) ? d3 + D3_W'(1) : d3;

      am_div = d3_am[18:3];
      case (d3_am[2:0])
         3'd0:              am_div = (d3_am[18:3] == 16'd1) ? 16'd0 : d3_am[18:3];
         3'd1:              am_div = d3_am[18:3] | AM_CODE_EIGHTH;
         3'd2, 3'd3:        am_div = d3_am[18:3] | AM_CODE_QUARTER;
         default:           am_div = d3_am[18:3] | AM_CODE_HALF;
      endcase

      frac_div = d3[34:3] | {15'd0, frac_code(d3[2:0]), 14'd0};
      // the two lowest divisors have codes of their own
      if (frac_div == 32'd1) begin
         frac_div = 32'd0;
      end else if (frac_div == BM_SPECIAL) begin
         frac_div = 32'd1;
      end

      case (cell_in.ctrl.mode)
         MODE_SIO: word = {28'd0, cell_in.ctrl.sio_idx};
         MODE_AM:  word = {16'd0, am_div};
         MODE_BM:  word = frac_div;
         MODE_HS:  word = frac_div | HS_FLAG;
         default:  word = '0;
      endcase

      idx = word[31:16];
      if (cell_in.ctrl.dual) begin
         idx = {idx[7:0], 8'd0} | {14'd0, cell_in.ctrl.ifn};
      end
      value_in = word[15:0];
      index_in = idx;
   end

   assign ready_in = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_in) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_in && valid_in) begin
         value_ff <= value_in;
         index_ff <= index_in;
         ok_ff    <= cell_in.ctrl.ok;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.divisor_value = value_ff;
   assign rsp.divisor_index = index_ff;
   assign rsp.rate_ok       = ok_ff;

endmodule
